FILE: src/sorted_unique_list_unit_defines.svh
// Assertion macros shared by the checker.
`ifndef SORTED_UNIQUE_LIST_UNIT_DEFINES_SVH
`define SORTED_UNIQUE_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SUL_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SUL_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sul_pkg.sv
package sul_pkg;

  localparam int CAPACITY    = 128;
  localparam int VALUE_WIDTH = 16;
  localparam int FILL_W      = $clog2(CAPACITY + 1);
  localparam int COUNT_W     = 8;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic   cmp_en;
    logic   apply_en;
    logic   remove;
    value_t value;
  } cell_ctl_t;

endpackage

FILE: src/sul_cell.sv
module sul_cell
  import sul_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      valid,
  input  value_t    left_entry,
  input  logic      left_gt,
  input  value_t    right_entry,
  output value_t    entry,
  output logic      gt,
  output logic      eq
);

  value_t entry_next;

  always_comb begin
    if (ctl.remove) begin
      entry_next = right_entry;
    end else if (left_gt) begin
      entry_next = left_entry;
    end else if (gt || !valid) begin
      entry_next = ctl.value;
    end else begin
      entry_next = entry;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      gt <= valid && (entry > ctl.value);
      eq <= valid && (entry == ctl.value);
    end
    if (ctl.apply_en) begin
      entry <= entry_next;
    end
  end

endmodule

FILE: src/sorted_unique_list_unit.sv
// Channel | Signals                        | Direction
// in      | in_valid, in_ready, mode, value | into block
// out     | out_valid, out_ready, status,   | out of block
//         | removed_value, smallest, count  |
//
// Each item passes through these steps: accept, compare in every cell, reduce the
// match flags, then shift the cell row and load the output register.
// A finished item waits in the output register; the next item is accepted
// while it waits, and its shift stalls only until that register is taken.
// Synchronous reset empties the list and clears the state machine and out_valid.
module sorted_unique_list_unit
  import sul_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  value_t             value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output value_t             removed_value,
  output value_t             smallest,
  output logic [COUNT_W-1:0] count
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_DEC   = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0]        state;
  logic              op_mode;
  value_t            op_value;
  logic              dup;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [1:0]        status_next;
  logic              out_free;
  logic              apply_go;
  value_t            smallest_next;
  cell_ctl_t         ctl;

  value_t        cell_entry [CAPACITY];
  logic          cell_gt    [CAPACITY];
  logic [CAPACITY-1:0] cell_eq;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign apply_go = (state == S_APPLY) && out_free;

  always_comb begin
    if (op_mode == MODE_INSERT) begin
      if (fill == FILL_W'(CAPACITY)) begin
        status_next = ST_FULL;
      end else if (dup) begin
        status_next = ST_DUP;
      end else begin
        status_next = ST_DONE;
      end
    end else begin
      status_next = (fill == '0) ? ST_EMPTY : ST_DONE;
    end
  end

  always_comb begin
    fill_next     = fill;
    smallest_next = cell_entry[0];
    if (status_next == ST_DONE) begin
      if (op_mode == MODE_INSERT) begin
        fill_next = fill + FILL_W'(1);
        if (fill == '0 || cell_gt[0]) begin
          smallest_next = op_value;
        end
      end else begin
        fill_next     = fill - FILL_W'(1);
        smallest_next = cell_entry[1];
      end
    end
  end

  always_comb begin
    ctl.cmp_en   = (state == S_CMP);
    ctl.apply_en = apply_go && (status_next == ST_DONE);
    ctl.remove   = (op_mode == MODE_REMOVE);
    ctl.value    = op_value;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t left_entry;
    value_t right_entry;
    logic   left_gt;
    logic   valid;

    assign valid = (fill > FILL_W'(i));

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_mid
      assign right_entry = cell_entry[i+1];
    end

    sul_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .valid       (valid),
      .left_entry  (left_entry),
      .left_gt     (left_gt),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .gt          (cell_gt[i]),
      .eq          (cell_eq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_DEC;
        end
        S_DEC: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (apply_go) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_mode  <= mode;
      op_value <= value;
    end
    if (state == S_DEC) begin
      dup <= |cell_eq;
    end
    if (apply_go) begin
      status        <= status_next;
      removed_value <= (op_mode == MODE_REMOVE && status_next == ST_DONE)
                       ? cell_entry[0] : '0;
      smallest      <= (fill_next != '0) ? smallest_next : '0;
      count         <= COUNT_W'(fill_next);
    end
  end

endmodule

FILE: src/sul_checker.sv
`include "sorted_unique_list_unit_defines.svh"

module sul_checker
  import sul_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               mode,
  input value_t             value,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input value_t             removed_value,
  input value_t             smallest,
  input logic [COUNT_W-1:0] count
);

  // hold a waiting input item
  `SUL_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
                   in_valid && $stable(mode) && $stable(value),
                   "waiting input item changed")

  // hold a stalled result
  `SUL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable({status, removed_value, smallest, count}),
                   "stalled result changed")

  // full only at capacity
  `SUL_ASSERT_NOW(a_full_count, out_valid && status == ST_FULL,
                  count == COUNT_W'(CAPACITY), "full reported below capacity")

  // empty reports zeros
  `SUL_ASSERT_NOW(a_empty_zero, out_valid && status == ST_EMPTY,
                  count == '0 && smallest == '0 && removed_value == '0,
                  "empty result not zero")

  // a refused (duplicate or full) item removes nothing
  `SUL_ASSERT_NOW(a_no_removed, out_valid && (status == ST_DUP || status == ST_FULL),
                  removed_value == '0, "ignored item reports a removed value")

endmodule

bind sorted_unique_list_unit sul_checker u_sul_checker (.*);

FILE: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sul_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SEGMENTS    = 12;
  localparam int SEG_ITEMS   = 155;

  typedef struct packed {
    logic [1:0]         status;
    value_t             removed;
    value_t             smallest;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  typedef struct packed {
    logic         op;
    value_t       v;
    logic         exact;
    list_result_t want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               mode = MODE_INSERT;
  value_t             value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  value_t             removed_value;
  value_t             smallest;
  logic [COUNT_W-1:0] count;

  logic               cur_exact = 1'b0;
  list_result_t       cur_want = '0;

  value_t             sorted_vals[$];
  list_result_t       pending_results[$];
  stim_row_t          directed_rows[$];
  int                 peak_fill = 0;
  int                 errors = 0;
  int                 items_sent = 0;
  int                 status_seen[4] = '{0, 0, 0, 0};
  int                 cycle_count = 0;
  bit                 gaps_on = 1'b1;
  int                 stall_left = 0;

  sorted_unique_list_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .removed_value(removed_value),
    .smallest     (smallest),
    .count        (count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic list_result_t apply_list_op(logic op, value_t v);
    list_result_t r;
    int           pos;
    r = '0;
    if (op == MODE_INSERT) begin
      if (sorted_vals.size() >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < sorted_vals.size() && sorted_vals[pos] < v) pos++;
        if (pos < sorted_vals.size() && sorted_vals[pos] == v) begin
          r.status = ST_DUP;
        end else begin
          sorted_vals.insert(pos, v);
          r.status = ST_DONE;
        end
      end
    end else if (sorted_vals.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.removed = sorted_vals.pop_front();
      r.status  = ST_DONE;
    end
    if (sorted_vals.size() > 0) r.smallest = sorted_vals[0];
    r.count = COUNT_W'(sorted_vals.size());
    if (sorted_vals.size() > peak_fill) peak_fill = sorted_vals.size();
    return r;
  endfunction

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endfunction

  function automatic void check_result(list_result_t got);
    list_result_t want;
    if (pending_results.size() == 0) begin
      note_error($sformatf(
        "result with nothing pending: status %0d removed %0d smallest %0d count %0d",
        got.status, got.removed, got.smallest, got.count));
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status)
      note_error($sformatf("status expected %0d got %0d", want.status, got.status));
    if (got.removed !== want.removed)
      note_error($sformatf("removed_value expected %0d got %0d", want.removed, got.removed));
    if (got.smallest !== want.smallest)
      note_error($sformatf("smallest expected %0d got %0d", want.smallest, got.smallest));
    if (got.count !== want.count)
      note_error($sformatf("count expected %0d got %0d", want.count, got.count));
    status_seen[want.status]++;
  endfunction

  always @(posedge clk) begin : monitor
    list_result_t predicted;
    if (!rst && in_valid && in_ready) begin
      predicted = apply_list_op(mode, value);
      pending_results.push_back(cur_exact ? cur_want : predicted);
    end
    if (!rst && out_valid && out_ready)
      check_result(list_result_t'({status, removed_value, smallest, count}));
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // hold off the result side in short random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic add_row(logic op, value_t v);
    stim_row_t row;
    row = '0;
    row.op = op;
    row.v  = v;
    directed_rows.push_back(row);
  endtask

  task automatic add_fixed(logic op, int v, logic [1:0] st, int rem, int sm, int cnt);
    stim_row_t row;
    row.op    = op;
    row.v     = value_t'(v);
    row.exact = 1'b1;
    row.want  = '{status: st, removed: value_t'(rem), smallest: value_t'(sm),
                  count: COUNT_W'(cnt)};
    directed_rows.push_back(row);
  endtask

  task automatic send_item(stim_row_t row);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= row.op;
    value     <= row.v;
    cur_exact <= row.exact;
    cur_want  <= row.want;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic value_t pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return value_t'($urandom);
    if (r < 8) return value_t'(int'($urandom_range(0, 64)) - 32);
    if (r == 9 && sorted_vals.size() > 0)
      return sorted_vals[$urandom_range(0, sorted_vals.size() - 1)];
    case ($urandom_range(0, 3))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  initial begin
    int        insert_pct[SEGMENTS] = '{95, 95, 60, 10, 5, 50, 95, 95, 30, 5, 70, 50};
    stim_row_t row;

    add_fixed(MODE_REMOVE, 'h1234, ST_EMPTY, 0, 0, 0);
    add_fixed(MODE_INSERT, 0, ST_DONE, 0, 0, 1);
    add_fixed(MODE_INSERT, -32768, ST_DONE, 0, -32768, 2);
    add_fixed(MODE_INSERT, 32767, ST_DONE, 0, -32768, 3);
    add_fixed(MODE_INSERT, 32767, ST_DUP, 0, -32768, 3);
    add_fixed(MODE_INSERT, -32768, ST_DUP, 0, -32768, 3);
    add_fixed(MODE_INSERT, -1, ST_DONE, 0, -32768, 4);
    add_fixed(MODE_INSERT, 1, ST_DONE, 0, -32768, 5);
    add_fixed(MODE_INSERT, -32767, ST_DONE, 0, -32768, 6);
    add_fixed(MODE_INSERT, 32766, ST_DONE, 0, -32768, 7);
    add_fixed(MODE_REMOVE, -1, ST_DONE, -32768, -32767, 6);
    add_fixed(MODE_REMOVE, 'h5555, ST_DONE, -32767, -1, 5);
    add_fixed(MODE_INSERT, 0, ST_DUP, 0, -1, 5);
    add_row(MODE_INSERT, 16'sh5555);
    add_row(MODE_INSERT, 16'shaaaa);
    repeat (7) add_row(MODE_REMOVE, 16'shaaaa);
    add_fixed(MODE_REMOVE, 0, ST_EMPTY, 0, 0, 0);
    add_fixed(MODE_REMOVE, 'h7fff, ST_EMPTY, 0, 0, 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) send_item(directed_rows[i]);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      gaps_on = (seg % 4 != 3) && (seg < SEGMENTS - 2);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        row    = '0;
        row.op = ($urandom_range(0, 99) < insert_pct[seg]) ? MODE_INSERT : MODE_REMOVE;
        row.v  = pick_value();
        send_item(row);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (pending_results.size() != 0) note_error("results left pending at end of run");

    $display("Sent %0d items; results: %0d done, %0d duplicate, %0d full, %0d empty",
             items_sent, status_seen[ST_DONE], status_seen[ST_DUP], status_seen[ST_FULL],
             status_seen[ST_EMPTY]);
    $display("Peak fill %0d of %0d entries, %0d errors", peak_fill, CAPACITY, errors);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
